FILE: hw/rtl/cpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_pkg: closest pair distance types and constants
// Sequencer states and the fixed widths of the stream words.
// ----------------------------------------------------------------------------
package cpd_pkg;

	// input word fields: point_x, point_y
	localparam int unsigned COORD_IN_W = 16;
	localparam int unsigned IN_DATA_W  = 2 * COORD_IN_W;

	// output word fields: min_sq_distance, distance_q16
	localparam int unsigned OUT_W      = 33;
	localparam int unsigned OUT_DATA_W = 72;
	localparam int unsigned OUT_USER_W = 2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RDI,
		S_GETI,
		S_DIFF,
		S_MULX,
		S_MULY,
		S_ACC,
		S_RSTART,
		S_ROOT,
		S_OUT
	} cpd_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cpd_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_isqrt: fixed point square root, one root bit per cycle
// Restoring digit-by-digit root of radicand * 4^FRAC_BITS, rounded down.
// ----------------------------------------------------------------------------
module cpd_isqrt #(
	parameter int unsigned RAD_W     = 33,
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned ROOT_W    = (RAD_W + 1) / 2 + FRAC_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [RAD_W-1:0]  radicand,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);

	localparam int unsigned NW    = 2 * ROOT_W;
	localparam int unsigned REM_W = ROOT_W + 3;
	localparam int unsigned SW    = $clog2(ROOT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [SW-1:0]     step_q;
	logic [NW-1:0]     rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[NW-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(ROOT_W);
			end else if (busy_q) begin
				step_q <= step_q - SW'(1);
				if (step_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= NW'(radicand) << (2 * FRAC_BITS);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

FILE: hw/rtl/closest_pair_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// Points load at one word per cycle while idle; a full store drops further points.
// After the last point of a set the pair search runs through one shared squarer:
// per pair it takes the differences, squares x then y and keeps the least sum;
// the square root of that sum is then taken before the result word is presented.
// Input is not ready from the last point until the result is registered.
// Async reset clears count, flags, sequencer and output valid; store contents are undefined.
// ----------------------------------------------------------------------------
// closest_pair_distance: minimum distance of a streamed 2-D point set
// Stores points, then walks every pair for the least squared distance and
// returns it with its fixed point square root.
// ----------------------------------------------------------------------------
module closest_pair_distance
	import cpd_pkg::*;
#(
	parameter int unsigned MAX_POINTS = 1024,
	parameter int unsigned COORD_BITS = 16,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // [15:0] point_x, [31:16] point_y
	input  wire logic                  s_tlast,  // is_last
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // [32:0] min_sq_distance, [65:33] distance_q16
	output logic [OUT_USER_W-1:0]      m_tuser   // [0] no_pair, [1] overflowed
);

	localparam int unsigned CW   = COORD_BITS;
	localparam int unsigned AW   = $clog2(MAX_POINTS);
	localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
	localparam int unsigned SQW  = 2 * CW + 1;
	localparam int unsigned RW   = CW + 1 + FRAC_BITS;

	cpd_state_t state_q, state_d;

	// store and counters
	logic [2*CW-1:0] store_q [MAX_POINTS];
	logic [2*CW-1:0] rd_data_q;
	logic [AW-1:0]   rd_addr;
	logic [CNTW-1:0] count_q, count_after;
	logic [CNTW-1:0] i_q, j_q;
	logic            dropped_q, nopair_q;
	logic            full, in_acc, more_j, more_i;

	// pair datapath
	logic [2*CW-1:0] a_q;
	logic [CW-1:0]   dx_q, dy_q, mul_opd;
	logic [2*CW-1:0] mul_q, sqx_q;
	logic [SQW-1:0]  pair_sq, best_q;
	logic [CW:0]     diff_x, diff_y, abs_x, abs_y;

	// root and output
	logic            root_start, root_done;
	logic [RW-1:0]   root_val;
	logic            out_load, m_tvalid_q;
	logic [OUT_W-1:0] out_sq_q, out_rt_q;
	logic            out_np_q, out_ov_q;

	logic [CW+COORD_IN_W-1:0] x_ext, y_ext;
	logic [SQW+OUT_W-1:0]     best_ext;
	logic [RW+OUT_W-1:0]      root_ext;

	// coordinates: low COORD_BITS bits, sign taken from the top one
	assign x_ext = {{CW{1'b0}}, s_tdata[COORD_IN_W-1:0]};
	assign y_ext = {{CW{1'b0}}, s_tdata[IN_DATA_W-1:COORD_IN_W]};

	assign in_acc      = s_tvalid && s_tready;
	assign full        = (count_q == CNTW'(MAX_POINTS));
	assign count_after = full ? count_q : count_q + CNTW'(1);
	assign more_j      = ((j_q + CNTW'(1)) < count_q);
	assign more_i      = ((i_q + CNTW'(2)) < count_q);
	assign out_load    = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && s_tlast)
					state_d = (count_after < CNTW'(2)) ? S_OUT : S_RDI;
			end
			S_RDI:    state_d = S_GETI;
			S_GETI:   state_d = S_DIFF;
			S_DIFF:   state_d = S_MULX;
			S_MULX:   state_d = S_MULY;
			S_MULY:   state_d = S_ACC;
			S_ACC: begin
				if (more_j)
					state_d = S_DIFF;
				else if (more_i)
					state_d = S_RDI;
				else
					state_d = S_RSTART;
			end
			S_RSTART: state_d = S_ROOT;
			S_ROOT: begin
				if (root_done)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load)
					state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		root_start = 1'b0;
		rd_addr    = i_q[AW-1:0];
		mul_opd    = dy_q;
		case (state_q)
			S_IDLE:   s_tready = 1'b1;
			S_RDI:    rd_addr = i_q[AW-1:0];
			S_GETI:   rd_addr = j_q[AW-1:0];
			S_MULX:   mul_opd = dx_q;
			S_ACC:    rd_addr = CNTW'(j_q + CNTW'(1)) < CNTW'(MAX_POINTS) ?
				AW'(j_q + CNTW'(1)) : i_q[AW-1:0];
			S_RSTART: root_start = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			dropped_q  <= 1'b0;
			nopair_q   <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			best_q     <= '1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (full)
							dropped_q <= 1'b1;
						else
							count_q <= count_q + CNTW'(1);
						if (s_tlast) begin
							i_q      <= '0;
							j_q      <= CNTW'(1);
							best_q   <= '1;
							nopair_q <= (count_after < CNTW'(2));
						end
					end
				end
				S_ACC: begin
					if (pair_sq < best_q)
						best_q <= pair_sq;
					if (more_j) begin
						j_q <= j_q + CNTW'(1);
					end else begin
						i_q <= i_q + CNTW'(1);
						j_q <= i_q + CNTW'(2);
					end
				end
				S_OUT: begin
					if (out_load) begin
						count_q    <= '0;
						dropped_q  <= 1'b0;
						best_q     <= '1;
					end
				end
				default: ;
			endcase
		end
	end

	// point store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && !full)
			store_q[count_q[AW-1:0]] <= {y_ext[CW-1:0], x_ext[CW-1:0]};
	end

	always_ff @(posedge clk) begin
		rd_data_q <= store_q[rd_addr];
	end

	// |a - b| per axis; the difference always fits CW+1 bits signed
	assign diff_x = {a_q[CW-1], a_q[CW-1:0]} - {rd_data_q[CW-1], rd_data_q[CW-1:0]};
	assign diff_y = {a_q[2*CW-1], a_q[2*CW-1:CW]} -
		{rd_data_q[2*CW-1], rd_data_q[2*CW-1:CW]};
	assign abs_x  = diff_x[CW] ? (~diff_x + (CW+1)'(1)) : diff_x;
	assign abs_y  = diff_y[CW] ? (~diff_y + (CW+1)'(1)) : diff_y;
	assign pair_sq = SQW'(sqx_q) + SQW'(mul_q);

	always_ff @(posedge clk) begin
		case (state_q)
			S_GETI: a_q <= rd_data_q;
			S_DIFF: begin
				dx_q <= abs_x[CW-1:0];
				dy_q <= abs_y[CW-1:0];
			end
			S_MULX: mul_q <= mul_opd * mul_opd;
			S_MULY: begin
				sqx_q <= mul_q;
				mul_q <= mul_opd * mul_opd;
			end
			default: ;
		endcase
	end

	cpd_isqrt #(
		.RAD_W     (SQW),
		.FRAC_BITS (FRAC_BITS),
		.ROOT_W    (RW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (best_q),
		.done     (root_done),
		.root     (root_val)
	);

	assign best_ext = {{OUT_W{1'b0}}, best_q};
	assign root_ext = {{OUT_W{1'b0}}, root_val};

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sq_q <= nopair_q ? '0 : best_ext[OUT_W-1:0];
			out_rt_q <= nopair_q ? '0 : root_ext[OUT_W-1:0];
			out_np_q <= nopair_q;
			out_ov_q <= dropped_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - 2*OUT_W){1'b0}}, out_rt_q, out_sq_q};
	assign m_tuser  = {out_ov_q, out_np_q};

`ifndef NO_ASSERTIONS
	a_root_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (state_q == S_ROOT))
		else $error("root finished outside its wait state");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIFF) |-> (j_q > i_q && j_q < count_q))
		else $error("pair index outside stored points");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid && state_q == S_IDLE && count_q == '0))
		else $error("result word not presented after search");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && full) |=> (dropped_q && count_q == CNTW'(MAX_POINTS)))
		else $error("point accepted into a full store");
`endif

endmodule
`default_nettype wire

FILE: sim/cpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_checker: scoreboard for closest_pair_distance
// Watches both stream channels, keeps its own copy of the point store and
// works out the closest pair for every set closed by tlast. Each result word
// is compared field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module cpd_checker
	import cpd_pkg::*;
#(
	parameter int unsigned MAX_POINTS = 1024,
	parameter int unsigned COORD_BITS = 16,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // [15:0] point_x, [31:16] point_y
	input  wire logic                  s_tlast,  // is_last
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,  // [32:0] min_sq_distance, [65:33] distance_q16
	input  wire logic [OUT_USER_W-1:0] m_tuser,  // [0] no_pair, [1] overflowed
	output int                         fail_count,
	output int                         waiting,
	output int                         results_checked
);

	localparam int MAX_REPORTS = 20;

	typedef struct packed {
		logic [OUT_W-1:0] sq_dist;
		logic [OUT_W-1:0] dist_q;
		logic             no_pair;
		logic             overflowed;
	} pair_result_t;

	longint       store_x [MAX_POINTS];
	longint       store_y [MAX_POINTS];
	int unsigned  stored;
	logic         dropped;
	pair_result_t pending_results [$];

	// low COORD_BITS of the field, sign-extended
	function automatic longint to_coord(logic [COORD_IN_W-1:0] raw);
		logic [63:0] v;
		v = 64'(raw) << (64 - COORD_BITS);
		return $signed(v) >>> (64 - COORD_BITS);
	endfunction

	// floor(sqrt(sq) * 2^FRAC_BITS), found bit by bit from the top
	function automatic logic [OUT_W-1:0] fixed_root(logic [63:0] sq);
		logic [127:0] target;
		logic [63:0]  root;
		logic [63:0]  trial;
		int           b;
		target = 128'(sq) << (2 * FRAC_BITS);
		root   = '0;
		for (b = 44; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (128'(trial) * 128'(trial) <= target)
				root = trial;
		end
		return root[OUT_W-1:0];
	endfunction

	function automatic pair_result_t closest_pair(int unsigned n, logic ovf);
		pair_result_t r;
		longint       dx;
		longint       dy;
		longint       d;
		longint       best;
		int unsigned  i;
		int unsigned  j;
		best = -1;
		for (i = 0; i < n; i++) begin
			for (j = i + 1; j < n; j++) begin
				dx = store_x[i] - store_x[j];
				dy = store_y[i] - store_y[j];
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				d = dx * dx + dy * dy;
				if (best < 0 || d < best)
					best = d;
			end
		end
		r.overflowed = ovf;
		if (n < 2) begin
			r.sq_dist = '0;
			r.dist_q  = '0;
			r.no_pair = 1'b1;
		end else begin
			r.sq_dist = OUT_W'(best);
			r.dist_q  = fixed_root(64'(best));
			r.no_pair = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (fail_count < MAX_REPORTS)
			$display("cpd_checker: result %0d %s: got %0d, expected %0d",
				results_checked, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pair_result_t want;
		if (!arst_n) begin
			stored          = 0;
			dropped         = 1'b0;
			fail_count      = 0;
			results_checked = 0;
			pending_results.delete();
			waiting <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (stored < MAX_POINTS) begin
					store_x[stored] = to_coord(s_tdata[COORD_IN_W-1:0]);
					store_y[stored] = to_coord(s_tdata[IN_DATA_W-1:COORD_IN_W]);
					stored++;
				end else begin
					dropped = 1'b1;
				end
				if (s_tlast) begin
					pending_results.push_back(closest_pair(stored, dropped));
					stored  = 0;
					dropped = 1'b0;
				end
			end
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("arrived with nothing outstanding, min_sq_distance",
						64'(m_tdata[OUT_W-1:0]), 64'd0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[OUT_W-1:0] !== want.sq_dist)
						report_mismatch("min_sq_distance", 64'(m_tdata[OUT_W-1:0]),
							64'(want.sq_dist));
					if (m_tdata[2*OUT_W-1:OUT_W] !== want.dist_q)
						report_mismatch("distance_q16", 64'(m_tdata[2*OUT_W-1:OUT_W]),
							64'(want.dist_q));
					if (m_tuser[0] !== want.no_pair)
						report_mismatch("no_pair", 64'(m_tuser[0]), 64'(want.no_pair));
					if (m_tuser[1] !== want.overflowed)
						report_mismatch("overflowed", 64'(m_tuser[1]), 64'(want.overflowed));
				end
				results_checked++;
			end
			waiting <= pending_results.size();
		end
	end

endmodule

FILE: sim/closest_pair_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_distance_tb: stream test of the closest pair search
// Streams directed and random point sets, one of them overrunning the store,
// with random gaps on both sides and one long output stall. The checker
// beside the block predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module closest_pair_distance_tb;
	import cpd_pkg::*;

	localparam int unsigned MAX_POINTS = 1024;
	localparam int unsigned COORD_BITS = 16;
	localparam int unsigned FRAC_BITS  = 16;
	localparam int          LONG_HOLD  = 400;
	localparam int          RANDOM_PTS = 800;
	localparam realtime     RUN_LIMIT  = 40ms;

	localparam logic signed [COORD_IN_W-1:0] COORD_MIN = 16'sh8000;
	localparam logic signed [COORD_IN_W-1:0] COORD_MAX = 16'sh7fff;

	typedef enum int {
		SPREAD_WIDE,
		SPREAD_CLUSTER,
		SPREAD_EXTREME
	} spread_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	int   fail_count;
	int   waiting;
	int   results_checked;
	int   points_sent;
	int   sets_sent;
	bit   tx_eager;
	bit   hold_req;
	bit   hold_done;

	closest_pair_distance #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	cpd_checker #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.fail_count      (fail_count),
		.waiting         (waiting),
		.results_checked (results_checked)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic send_point(input logic signed [COORD_IN_W-1:0] x,
			input logic signed [COORD_IN_W-1:0] y, input logic last);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= IN_DATA_W'($urandom);
			s_tlast  <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		points_sent++;
		if (last)
			sets_sent++;
	endtask

	function automatic logic signed [COORD_IN_W-1:0] pick_coord(spread_t spread,
			logic signed [COORD_IN_W-1:0] centre);
		case (spread)
			SPREAD_CLUSTER: return centre + COORD_IN_W'($urandom_range(0, 6)) - 16'sd3;
			SPREAD_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return COORD_MIN;
					1: return COORD_MIN + 16'sd1;
					2: return -16'sd1;
					3: return 16'sd0;
					4: return COORD_MAX - 16'sd1;
					default: return COORD_MAX;
				endcase
			end
			default: return COORD_IN_W'($urandom);
		endcase
	endfunction

	task automatic send_random_set(input int n, input spread_t spread);
		logic signed [COORD_IN_W-1:0] cx;
		logic signed [COORD_IN_W-1:0] cy;
		int k;
		cx = COORD_IN_W'($urandom);
		cy = COORD_IN_W'($urandom);
		for (k = 0; k < n; k++)
			send_point(pick_coord(spread, cx), pick_coord(spread, cy), k == n - 1);
	endtask

	task automatic random_sets(input int npoints);
		int start;
		int n;
		start = points_sent;
		while (points_sent - start < npoints) begin
			if ($urandom_range(0, 5) == 0)
				tx_eager = !tx_eager;
			case ($urandom_range(0, 9))
				0: n = 1;
				1: n = $urandom_range(13, 24);
				default: n = $urandom_range(2, 12);
			endcase
			send_random_set(n, spread_t'($urandom_range(0, 2)));
		end
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	// output side: random stalls per word, eager stretches, one long hold-off
	initial begin
		bit rx_eager;
		int stall;
		m_tready  = 1'b0;
		hold_done = 1'b0;
		rx_eager  = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end
			stall = rx_eager ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if ($urandom_range(0, 7) == 0)
				rx_eager = !rx_eager;
		end
	end

	initial begin
		int k;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		tx_eager    = 1'b0;
		hold_req    = 1'b0;
		points_sent = 0;
		sets_sent   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone point: no pair to measure
		send_point(16'sd0, 16'sd0, 1'b1);
		// opposite corners, largest possible distance
		send_point(COORD_MIN, COORD_MIN, 1'b0);
		send_point(COORD_MAX, COORD_MAX, 1'b1);
		send_point(COORD_MAX, COORD_MIN, 1'b0);
		send_point(COORD_MIN, COORD_MAX, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(-16'sd1, -16'sd1, 1'b1);
		// duplicate points give zero
		send_point(16'sd5, -16'sd7, 1'b0);
		send_point(16'sd5, -16'sd7, 1'b0);
		send_point(16'sd300, -16'sd300, 1'b1);
		send_point(COORD_MIN, 16'sd0, 1'b0);
		send_point(COORD_MAX, 16'sd0, 1'b0);
		send_point(16'sd0, COORD_MIN, 1'b0);
		send_point(16'sd0, COORD_MAX, 1'b1);
		// exact root
		send_point(16'sd100, 16'sd200, 1'b0);
		send_point(16'sd103, 16'sd204, 1'b1);
		drain();

		// back-to-back sets while the output is held off: the block must stall
		hold_req = 1'b1;
		tx_eager = 1'b1;
		for (k = 0; k < 6; k++)
			send_random_set(4, SPREAD_WIDE);
		tx_eager = 1'b0;
		drain();

		random_sets(RANDOM_PTS / 2);
		drain();
		// one set overruns the store, tlast itself among the dropped points
		send_random_set(MAX_POINTS + 3, SPREAD_WIDE);
		drain();
		random_sets(RANDOM_PTS / 2);
		drain();
		repeat (100) @(posedge clk);

		$display("Streamed %0d points in %0d sets, one of them past the %0d-entry store.",
			points_sent, sets_sent, MAX_POINTS);
		$display("Checked %0d result words, with random gaps and a %0d-cycle output stall.",
			results_checked, LONG_HOLD);
		if (fail_count == 0 && waiting == 0)
			$display("closest_pair_distance test passed");
		else
			$display("closest_pair_distance test failed");
		$finish;
	end

	initial begin
		#RUN_LIMIT;
		$display("Timed out with %0d results outstanding.", waiting);
		$display("closest_pair_distance test failed");
		$finish;
	end

endmodule
